FILE: hw/rtl/plfs_pkg.sv
// Shared types, widths, register indexes and saturation helper for the
// line-follow steering controller. Depends on nothing.
`timescale 1ns / 1ps

package plfs_pkg;

  // Widths of the measured position and of the gains' fractional part.
  localparam int POS_W     = 10;
  localparam int GAIN_FRAC = 8;

  // Fixed register and data widths.
  localparam int TGT_W   = 10;
  localparam int THR_W   = 10;
  localparam int LIM_W   = 15;
  localparam int DATA_W  = 16;
  localparam int ROTT_W  = 15;
  localparam int COEF_W  = 8;
  localparam int CFG_IDX_W = 4;

  // Derived datapath widths.
  localparam int ERR_W  = ((POS_W > TGT_W) ? POS_W : TGT_W) + 1;
  localparam int SUM_W  = ((ERR_W > DATA_W) ? ERR_W : DATA_W) + 1;
  localparam int MUL_W  = (ERR_W > DATA_W + 1) ? ERR_W : DATA_W + 1;
  localparam int PROD_W = 2 * MUL_W;
  localparam int ACC_W  = PROD_W + 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET       = 4'd0,
    REG_DEAD_ZONE    = 4'd1,
    REG_INTEG_LIMIT  = 4'd2,
    REG_KP           = 4'd3,
    REG_KI           = 4'd4,
    REG_TURN_MIN     = 4'd5,
    REG_TURN_GAIN    = 4'd6,
    REG_CRUISE_SPEED = 4'd7
  } reg_idx_t;

  typedef struct packed {
    logic [TGT_W-1:0]         target;
    logic [THR_W-1:0]         dead_zone;
    logic [LIM_W-1:0]         integ_limit;
    logic signed [DATA_W-1:0] kp;
    logic signed [DATA_W-1:0] ki;
    logic [ROTT_W-1:0]        turn_min;
    logic [COEF_W-1:0]        turn_gain;
    logic signed [DATA_W-1:0] cruise_speed;
  } cfg_t;

  // Clamp a wide signed value into the 16-bit signed range.
  function automatic logic signed [DATA_W-1:0] sat_acc(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = ACC_W'(32767);
    lo = ACC_W'(-32768);
    if (v > hi) begin
      sat_acc = 16'sh7FFF;
    end else if (v < lo) begin
      sat_acc = 16'sh8000;
    end else begin
      sat_acc = v[DATA_W-1:0];
    end
  endfunction

endpackage

FILE: hw/rtl/plfs_cfg.sv
// Configuration register file of the line-follow steering controller.
// Depends on plfs_pkg for the register indexes and the cfg_t bundle.
`timescale 1ns / 1ps

module plfs_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           we,
  input  logic [plfs_pkg::CFG_IDX_W-1:0] idx,
  input  logic [plfs_pkg::DATA_W-1:0]    wdata,
  output plfs_pkg::cfg_t                 cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target       <= plfs_pkg::TGT_W'(512);
      cfg.dead_zone    <= '0;
      cfg.integ_limit  <= plfs_pkg::LIM_W'(32767);
      cfg.kp           <= plfs_pkg::DATA_W'(256);
      cfg.ki           <= '0;
      cfg.turn_min     <= '0;
      cfg.turn_gain    <= plfs_pkg::COEF_W'(2);
      cfg.cruise_speed <= '0;
    end else if (we) begin
      // Only the register's low bits are kept; unknown indexes are dropped.
      case (plfs_pkg::reg_idx_t'(idx))
        plfs_pkg::REG_TARGET:       cfg.target <= wdata[plfs_pkg::TGT_W-1:0];
        plfs_pkg::REG_DEAD_ZONE:    cfg.dead_zone <= wdata[plfs_pkg::THR_W-1:0];
        plfs_pkg::REG_INTEG_LIMIT:  cfg.integ_limit <= wdata[plfs_pkg::LIM_W-1:0];
        plfs_pkg::REG_KP:           cfg.kp <= wdata;
        plfs_pkg::REG_KI:           cfg.ki <= wdata;
        plfs_pkg::REG_TURN_MIN:     cfg.turn_min <= wdata[plfs_pkg::ROTT_W-1:0];
        plfs_pkg::REG_TURN_GAIN:    cfg.turn_gain <= wdata[plfs_pkg::COEF_W-1:0];
        plfs_pkg::REG_CRUISE_SPEED: cfg.cruise_speed <= wdata;
        default: begin
        end
      endcase
    end
  end

endmodule

FILE: hw/rtl/pi_line_follow_steering_top.sv
// Top level of the PI line-follow steering controller: sequencer, shared
// multiplier and output register. Depends on plfs_pkg and plfs_cfg.
`timescale 1ns / 1ps

// Each accepted word carries one measured line position and produces exactly
// one result word: the steering correction, the right and left wheel speeds
// and a deadband flag. The error (position minus target) is integrated into a
// clamped signed accumulator unless its magnitude is inside the deadband, and
// the correction kp*error + ki*integral uses Q8.8 gains, truncated toward zero
// and saturated to 16 bits. A single 17x17 signed multiplier is shared by the
// three products (kp*error, ki*integral, coeff*correction) under a small
// sequencer: after the accepting edge a word passes through seven working
// steps and its result word is registered in the last one; a new word can
// be accepted only after that, since in_ready is high only while the
// sequencer is idle. The result sits in an output register, so a new word is
// accepted while the previous result still waits for out_ready; a result that
// is not taken before the next word reaches its last step holds the sequencer
// in that step. Configuration writes on the cfg port are always accepted
// (cfg_ready is tied high) and must only be issued while the block is idle.
// Register indexes 0 to 7 follow the register list; writes to other indexes
// are ignored.

module pi_line_follow_steering_top (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [plfs_pkg::POS_W-1:0]            line_position,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [plfs_pkg::DATA_W-1:0]    correction,
  output logic signed [plfs_pkg::DATA_W-1:0]    right_speed,
  output logic signed [plfs_pkg::DATA_W-1:0]    left_speed,
  output logic                                  in_deadband,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [plfs_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [plfs_pkg::DATA_W-1:0]           cfg_data
);

  // One-hot sequencer states.
  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_ERR  = 8'b0000_0010,
    S_MP   = 8'b0000_0100,
    S_MI   = 8'b0000_1000,
    S_SUM  = 8'b0001_0000,
    S_CORR = 8'b0010_0000,
    S_ROT  = 8'b0100_0000,
    S_SPD  = 8'b1000_0000
  } state_t;

  state_t state;
  plfs_pkg::cfg_t cfg;

  // Item registers.
  logic [plfs_pkg::POS_W-1:0]          pos;
  logic signed [plfs_pkg::ERR_W-1:0]   err;
  logic                                dead;
  logic signed [plfs_pkg::DATA_W-1:0]  integral;
  logic signed [plfs_pkg::PROD_W-1:0]  prod;
  logic signed [plfs_pkg::ACC_W-1:0]   acc;
  logic signed [plfs_pkg::DATA_W-1:0]  corr;

  // Combinational datapath.
  logic signed [plfs_pkg::ERR_W-1:0]   err_next;
  logic [plfs_pkg::ERR_W-1:0]          err_mag;
  logic                                dead_next;
  logic signed [plfs_pkg::SUM_W-1:0]   sum_raw;
  logic signed [plfs_pkg::SUM_W-1:0]   sum_lim;
  logic signed [plfs_pkg::DATA_W-1:0]  integral_next;
  logic signed [plfs_pkg::MUL_W-1:0]   mul_a;
  logic signed [plfs_pkg::MUL_W-1:0]   mul_b;
  logic signed [plfs_pkg::PROD_W-1:0]  mul_p;
  logic signed [plfs_pkg::ACC_W-1:0]   round_bias;
  logic signed [plfs_pkg::ACC_W-1:0]   acc_shift;
  logic signed [plfs_pkg::DATA_W-1:0]  corr_sat;
  logic signed [plfs_pkg::DATA_W:0]    corr_wide;
  logic [plfs_pkg::DATA_W:0]           corr_mag;
  logic signed [plfs_pkg::DATA_W-1:0]  corr_next;
  logic signed [plfs_pkg::ACC_W-1:0]   base_wide;
  logic signed [plfs_pkg::ACC_W-1:0]   rot_wide;
  logic                                out_free;

  plfs_cfg u_cfg (
    .clk   (clk),
    .rst   (rst),
    .we    (cfg_valid && cfg_ready),
    .idx   (cfg_index),
    .wdata (cfg_data),
    .cfg   (cfg)
  );

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign out_free  = !out_valid || out_ready;

  // Error, deadband decision and clamped integral update.
  always_comb begin
    err_next = $signed(plfs_pkg::ERR_W'(pos)) - $signed(plfs_pkg::ERR_W'(cfg.target));
    err_mag  = err_next[plfs_pkg::ERR_W-1] ? plfs_pkg::ERR_W'(-err_next)
                                           : plfs_pkg::ERR_W'(err_next);
    dead_next = err_mag < plfs_pkg::ERR_W'(cfg.dead_zone);
    sum_raw   = plfs_pkg::SUM_W'(integral) + plfs_pkg::SUM_W'(err_next);
    sum_lim   = $signed(plfs_pkg::SUM_W'(cfg.integ_limit));
    if (sum_raw > sum_lim) begin
      integral_next = sum_lim[plfs_pkg::DATA_W-1:0];
    end else if (sum_raw < -sum_lim) begin
      integral_next = plfs_pkg::DATA_W'(-sum_lim);
    end else begin
      integral_next = sum_raw[plfs_pkg::DATA_W-1:0];
    end
  end

  // Shared multiplier operand selection.
  always_comb begin
    case (state)
      S_MP: begin
        mul_a = plfs_pkg::MUL_W'(cfg.kp);
        mul_b = plfs_pkg::MUL_W'(err);
      end
      S_MI: begin
        mul_a = plfs_pkg::MUL_W'(cfg.ki);
        mul_b = plfs_pkg::MUL_W'(integral);
      end
      S_ROT: begin
        mul_a = $signed(plfs_pkg::MUL_W'(cfg.turn_gain));
        mul_b = plfs_pkg::MUL_W'(corr);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = plfs_pkg::PROD_W'(mul_a) * plfs_pkg::PROD_W'(mul_b);

  // Divide by the gain scale with truncation toward zero, saturate, then
  // apply the deadband and the rotation threshold.
  always_comb begin
    round_bias = acc[plfs_pkg::ACC_W-1] ?
                 plfs_pkg::ACC_W'((1 << plfs_pkg::GAIN_FRAC) - 1) : '0;
    acc_shift  = (acc + round_bias) >>> plfs_pkg::GAIN_FRAC;
    corr_sat   = dead ? '0 : plfs_pkg::sat_acc(acc_shift);
    corr_wide  = (plfs_pkg::DATA_W + 1)'(corr_sat);
    corr_mag   = corr_wide[plfs_pkg::DATA_W] ? (plfs_pkg::DATA_W + 1)'(-corr_wide)
                                             : (plfs_pkg::DATA_W + 1)'(corr_wide);
    corr_next  = (corr_mag < (plfs_pkg::DATA_W + 1)'(cfg.turn_min)) ? '0 : corr_sat;
  end

  assign base_wide = plfs_pkg::ACC_W'(cfg.cruise_speed);
  assign rot_wide  = plfs_pkg::ACC_W'(prod);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      integral  <= '0;
    end else begin
      // The last step reloads the output register on its own.
      if (out_valid && out_ready && state != S_SPD) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            pos   <= line_position;
            state <= S_ERR;
          end
        end
        S_ERR: begin
          err  <= err_next;
          dead <= dead_next;
          if (!dead_next) begin
            integral <= integral_next;
          end
          state <= S_MP;
        end
        S_MP: begin
          prod  <= mul_p;
          state <= S_MI;
        end
        S_MI: begin
          acc   <= plfs_pkg::ACC_W'(prod);
          prod  <= mul_p;
          state <= S_SUM;
        end
        S_SUM: begin
          acc   <= acc + plfs_pkg::ACC_W'(prod);
          state <= S_CORR;
        end
        S_CORR: begin
          corr  <= corr_next;
          state <= S_ROT;
        end
        S_ROT: begin
          prod  <= mul_p;
          state <= S_SPD;
        end
        S_SPD: begin
          // Wait here until the output register is free.
          if (out_free) begin
            correction  <= corr;
            right_speed <= plfs_pkg::sat_acc(base_wide - rot_wide);
            left_speed  <= plfs_pkg::sat_acc(base_wide + rot_wide);
            in_deadband <= dead;
            out_valid   <= 1'b1;
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: hw/rtl/plfs_checker.sv
// Port-level checker for the line-follow steering controller, bound to the
// top level. Depends on plfs_pkg for widths.
`timescale 1ns / 1ps

module plfs_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [plfs_pkg::DATA_W-1:0] correction,
  input logic signed [plfs_pkg::DATA_W-1:0] right_speed,
  input logic signed [plfs_pkg::DATA_W-1:0] left_speed,
  input logic                               in_deadband
);

  // A stalled result word keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(correction) &&
    $stable(left_speed) && $stable(right_speed) && $stable(in_deadband))
    else $error("result word changed while stalled");

  // The block works on one word at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a word is in progress");

  // Inside the deadband no correction is issued.
  a_dead_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && in_deadband |-> correction == '0)
    else $error("nonzero correction inside deadband");

  // Without a correction both wheels run at the same speed.
  a_equal_speeds: assert property (@(posedge clk) disable iff (rst)
    out_valid && correction == '0 |-> left_speed == right_speed)
    else $error("wheel speeds differ with zero correction");

endmodule

bind pi_line_follow_steering_top plfs_checker u_plfs_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .correction  (correction),
  .right_speed (right_speed),
  .left_speed  (left_speed),
  .in_deadband (in_deadband)
);

FILE: sim/testbench.sv
// Self-checking testbench for pi_line_follow_steering_top: directed and random
// line positions with an in-bench predictor and scoreboard. Depends on plfs_pkg.
`timescale 1ns / 1ps

module testbench;

  // One expected result word as the block should present it.
  typedef struct {
    logic signed [plfs_pkg::DATA_W-1:0] correction;
    logic signed [plfs_pkg::DATA_W-1:0] right_speed;
    logic signed [plfs_pkg::DATA_W-1:0] left_speed;
    logic                               in_deadband;
  } steer_result_t;

  // The scoreboard keeps its own copy of the registers and of the integral.
  // Every accepted position word is turned into one expected result word
  // right away, since the registers only change while the block is idle.
  class steer_scoreboard;
    plfs_pkg::cfg_t                     regs;
    logic signed [plfs_pkg::DATA_W-1:0] integral;
    steer_result_t                      expected_steer[$];
    int                                 failures;

    function new();
      regs.target       = 10'd512;
      regs.dead_zone    = '0;
      regs.integ_limit  = 15'h7FFF;
      regs.kp           = 16'sd256;
      regs.ki           = '0;
      regs.turn_min     = '0;
      regs.turn_gain    = 8'd2;
      regs.cruise_speed = '0;
      integral          = '0;
      failures          = 0;
    endfunction

    function logic signed [plfs_pkg::DATA_W-1:0] clamp16(longint v);
      if (v > 32767) begin
        return 16'sh7FFF;
      end
      if (v < -32768) begin
        return 16'sh8000;
      end
      return v[plfs_pkg::DATA_W-1:0];
    endfunction

    // Only the low bits of a register survive; unknown indexes are dropped.
    function void note_reg_write(logic [plfs_pkg::CFG_IDX_W-1:0] idx,
                                 logic [plfs_pkg::DATA_W-1:0] data);
      case (idx)
        plfs_pkg::REG_TARGET:       regs.target       = data[plfs_pkg::TGT_W-1:0];
        plfs_pkg::REG_DEAD_ZONE:    regs.dead_zone    = data[plfs_pkg::THR_W-1:0];
        plfs_pkg::REG_INTEG_LIMIT:  regs.integ_limit  = data[plfs_pkg::LIM_W-1:0];
        plfs_pkg::REG_KP:           regs.kp           = data;
        plfs_pkg::REG_KI:           regs.ki           = data;
        plfs_pkg::REG_TURN_MIN:     regs.turn_min     = data[plfs_pkg::ROTT_W-1:0];
        plfs_pkg::REG_TURN_GAIN:    regs.turn_gain    = data[plfs_pkg::COEF_W-1:0];
        plfs_pkg::REG_CRUISE_SPEED: regs.cruise_speed = data;
        default: ;
      endcase
    endfunction

    function void note_position(logic [plfs_pkg::POS_W-1:0] pos);
      longint        err, mag, lim, total, corr, amag, base, coeff;
      steer_result_t want;
      err  = longint'(pos) - longint'(regs.target);
      mag  = (err < 0) ? -err : err;
      want.in_deadband = (mag < longint'(regs.dead_zone));
      corr = 0;
      if (!want.in_deadband) begin
        lim   = longint'(regs.integ_limit);
        total = longint'(integral) + err;
        if (total > lim) begin
          total = lim;
        end else if (total < -lim) begin
          total = -lim;
        end
        integral = total[plfs_pkg::DATA_W-1:0];
        // Exact sum of products, then divide with truncation toward zero.
        total = longint'($signed(regs.kp)) * err + longint'($signed(regs.ki)) * total;
        total = total / (longint'(1) << plfs_pkg::GAIN_FRAC);
        corr  = longint'(clamp16(total));
      end
      amag = (corr < 0) ? -corr : corr;
      if (amag < longint'(regs.turn_min)) begin
        corr = 0;
      end
      base  = longint'($signed(regs.cruise_speed));
      coeff = longint'(regs.turn_gain);
      want.correction  = corr[plfs_pkg::DATA_W-1:0];
      want.right_speed = clamp16(base - coeff * corr);
      want.left_speed  = clamp16(base + coeff * corr);
      expected_steer.push_back(want);
    endfunction

    function void check_steering(logic signed [plfs_pkg::DATA_W-1:0] corr,
                                 logic signed [plfs_pkg::DATA_W-1:0] right,
                                 logic signed [plfs_pkg::DATA_W-1:0] left,
                                 logic dead);
      steer_result_t want;
      if (expected_steer.size() == 0) begin
        $error("unexpected result word: correction %0d", corr);
        failures++;
        return;
      end
      want = expected_steer.pop_front();
      if (corr !== want.correction) begin
        $error("correction: expected %0d, actual %0d", want.correction, corr);
        failures++;
      end
      if (right !== want.right_speed) begin
        $error("right_speed: expected %0d, actual %0d", want.right_speed, right);
        failures++;
      end
      if (left !== want.left_speed) begin
        $error("left_speed: expected %0d, actual %0d", want.left_speed, left);
        failures++;
      end
      if (dead !== want.in_deadband) begin
        $error("in_deadband: expected %0b, actual %0b", want.in_deadband, dead);
        failures++;
      end
    endfunction
  endclass

  // A watchdog ends the run once its count of handshake-free cycles hits this limit.
  // The longest legal quiet stretch is the deliberate receiver hold.
  localparam int QUIET_LIMIT  = 1000;
  localparam int HOLD_CYCLES  = 300;
  localparam int IDLE_SETTLE  = 16;
  localparam int RAND_PHASES  = 10;
  localparam int PHASE_WORDS  = 63;

  logic                               clk;
  logic                               rst;
  logic                               in_valid;
  logic                               in_ready;
  logic [plfs_pkg::POS_W-1:0]         line_position;
  logic                               out_valid;
  logic                               out_ready;
  logic signed [plfs_pkg::DATA_W-1:0] correction;
  logic signed [plfs_pkg::DATA_W-1:0] right_speed;
  logic signed [plfs_pkg::DATA_W-1:0] left_speed;
  logic                               in_deadband;
  logic                               cfg_valid;
  logic                               cfg_ready;
  logic [plfs_pkg::CFG_IDX_W-1:0]     cfg_index;
  logic [plfs_pkg::DATA_W-1:0]        cfg_data;

  steer_scoreboard steer_sb = new();

  // Idle pattern state of the sender: runs of words either with random gaps
  // or back to back.
  int send_run_left = 0;
  bit send_no_idle  = 0;
  // Set by the stimulus to make the receiver hold off for a long stretch.
  bit hold_results  = 0;
  int quiet_cycles  = 0;

  pi_line_follow_steering_top dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .line_position (line_position),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .correction    (correction),
    .right_speed   (right_speed),
    .left_speed    (left_speed),
    .in_deadband   (in_deadband),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Offer one position word and return at the edge where it is taken. The
  // valid is only lowered when a gap follows, so back-to-back words never
  // see valid dropped and raised in the same step.
  task automatic send_position(input logic [plfs_pkg::POS_W-1:0] pos);
    int gap;
    if (send_run_left == 0) begin
      send_run_left = $urandom_range(8, 40);
      send_no_idle  = ($urandom_range(0, 3) == 0);
    end
    send_run_left--;
    gap = send_no_idle ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    line_position <= pos;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    steer_sb.note_position(pos);
  endtask

  // Register writes leave cfg_valid high; the caller lowers it after a group.
  task automatic write_reg(input logic [plfs_pkg::CFG_IDX_W-1:0] idx,
                           input logic [plfs_pkg::DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    steer_sb.note_reg_write(idx, data);
  endtask

  // Registers may only change with the block idle: the last word is no
  // longer offered, every result is back and the sequencer has had time to
  // return to its idle step.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (steer_sb.expected_steer.size() != 0) @(posedge clk);
    repeat (IDLE_SETTLE) @(posedge clk);
  endtask

  // Endpoints with a fair share of the draws, random values otherwise.
  function automatic int pick_span(int lo, int hi);
    int sel;
    sel = $urandom_range(0, 7);
    if (sel == 0) begin
      return lo;
    end
    if (sel == 1) begin
      return hi;
    end
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  // Result side: random stalls in runs like the sender, plus one long hold
  // on request, during which the block fills up and stops taking words.
  initial begin : result_sink
    int gap;
    int run_left;
    bit no_idle;
    run_left = 0;
    no_idle  = 0;
    out_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (run_left == 0) begin
        run_left = $urandom_range(8, 40);
        no_idle  = ($urandom_range(0, 3) == 0);
      end
      run_left--;
      gap = no_idle ? 0 : $urandom_range(0, 13);
      if (hold_results) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_results = 0;
      end else if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      steer_sb.check_steering(correction, right_speed, left_speed, in_deadband);
    end
  end

  // Any handshake on any channel counts as progress.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("pi_line_follow_steering_top verification failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int reg_w[8];
    int val;
    int mid;
    int span;
    int pos;
    logic [plfs_pkg::DATA_W-1:0] mask;
    logic [plfs_pkg::DATA_W-1:0] junk;

    reg_w = '{plfs_pkg::TGT_W, plfs_pkg::THR_W, plfs_pkg::LIM_W, plfs_pkg::DATA_W,
              plfs_pkg::DATA_W, plfs_pkg::ROTT_W, plfs_pkg::COEF_W, plfs_pkg::DATA_W};
    rst           <= 1'b1;
    in_valid      <= 1'b0;
    line_position <= '0;
    cfg_valid     <= 1'b0;
    cfg_index     <= '0;
    cfg_data      <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: unit proportional gain around the image center. Covers
    // both position extremes, zero error, and alternating bit patterns.
    send_position(10'd0);
    send_position(10'd1023);
    send_position(10'd512);
    send_position(10'd511);
    send_position(10'd513);
    send_position(10'h2AA);
    send_position(10'h155);
    wait_idle();

    // Extreme gains and speeds. The target write carries ones above bit 9
    // that must be dropped, and one write goes to an index past the list.
    write_reg(plfs_pkg::REG_TARGET, 16'hFFFF);
    write_reg(plfs_pkg::REG_DEAD_ZONE, 16'd5);
    write_reg(plfs_pkg::REG_INTEG_LIMIT, 16'd700);
    write_reg(plfs_pkg::REG_KP, 16'h7FFF);
    write_reg(plfs_pkg::REG_KI, 16'h8000);
    write_reg(plfs_pkg::REG_TURN_MIN, 16'h7FFF);
    write_reg(plfs_pkg::REG_TURN_GAIN, 16'd255);
    write_reg(plfs_pkg::REG_CRUISE_SPEED, 16'h7FFF);
    write_reg(plfs_pkg::CFG_IDX_W'(plfs_pkg::REG_CRUISE_SPEED + 2), 16'h0000);
    cfg_valid <= 1'b0;
    // Zero error and an error of four sit inside the deadband, five does
    // not. The large negative error clamps the integral, saturates the
    // correction at -32768, which still passes the rotation threshold, and
    // drives both speeds into saturation.
    send_position(10'd1023);
    send_position(10'd1019);
    send_position(10'd1018);
    send_position(10'd0);
    send_position(10'd0);
    wait_idle();

    // No integration at all, tiny proportional gain: small negative
    // products must truncate toward zero, not round down.
    write_reg(plfs_pkg::REG_TARGET, 16'd512);
    write_reg(plfs_pkg::REG_DEAD_ZONE, 16'd0);
    write_reg(plfs_pkg::REG_INTEG_LIMIT, 16'd0);
    write_reg(plfs_pkg::REG_KP, 16'd1);
    write_reg(plfs_pkg::REG_KI, 16'h7FFF);
    write_reg(plfs_pkg::REG_TURN_MIN, 16'd0);
    write_reg(plfs_pkg::REG_TURN_GAIN, 16'd0);
    write_reg(plfs_pkg::REG_CRUISE_SPEED, 16'h8000);
    cfg_valid <= 1'b0;
    send_position(10'd257);
    send_position(10'd0);
    send_position(10'd1023);
    wait_idle();

    // Rotation threshold of ten: corrections of nine are zeroed, ten pass.
    write_reg(plfs_pkg::REG_INTEG_LIMIT, 16'h7FFF);
    write_reg(plfs_pkg::REG_KP, 16'd256);
    write_reg(plfs_pkg::REG_KI, 16'd0);
    write_reg(plfs_pkg::REG_TURN_MIN, 16'd10);
    write_reg(plfs_pkg::REG_TURN_GAIN, 16'd2);
    write_reg(plfs_pkg::REG_CRUISE_SPEED, 16'd0);
    cfg_valid <= 1'b0;
    send_position(10'd521);
    send_position(10'd522);
    send_position(10'd502);
    send_position(10'd503);
    wait_idle();

    // Random phases. Gains are mostly moderate so the integral and the
    // rotation threshold matter; now and then they jump to the extremes.
    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      for (int r = 0; r < 8; r++) begin
        if (phase != 0 && $urandom_range(0, 3) == 0) begin
          continue;
        end
        case (r)
          plfs_pkg::REG_TARGET: begin
            val = pick_span(0, 1023);
          end
          plfs_pkg::REG_DEAD_ZONE: begin
            val = ($urandom_range(0, 5) == 0) ? pick_span(0, 1023) : $urandom_range(0, 24);
          end
          plfs_pkg::REG_INTEG_LIMIT: begin
            val = $urandom_range(0, 1) ? $urandom_range(0, 2000) : pick_span(0, 32767);
          end
          plfs_pkg::REG_KP: begin
            val = ($urandom_range(0, 3) == 0) ? pick_span(-32768, 32767)
                                              : pick_span(-1024, 1024);
          end
          plfs_pkg::REG_KI: begin
            val = ($urandom_range(0, 3) == 0) ? pick_span(-32768, 32767)
                                              : pick_span(-128, 128);
          end
          plfs_pkg::REG_TURN_MIN: begin
            val = ($urandom_range(0, 4) == 0) ? pick_span(0, 32767) : $urandom_range(0, 300);
          end
          plfs_pkg::REG_TURN_GAIN: begin
            val = pick_span(0, 255);
          end
          default: begin
            val = pick_span(-32768, 32767);
          end
        endcase
        // Narrow registers sometimes get garbage above their width.
        mask = plfs_pkg::DATA_W'((32'd1 << reg_w[r]) - 1);
        junk = $urandom_range(0, 1) ? plfs_pkg::DATA_W'($urandom()) : '0;
        write_reg(plfs_pkg::CFG_IDX_W'(r),
                  (plfs_pkg::DATA_W'(val) & mask) | (junk & ~mask));
      end
      if ($urandom_range(0, 2) == 0) begin
        write_reg(plfs_pkg::CFG_IDX_W'(plfs_pkg::REG_CRUISE_SPEED + 1 +
                                       $urandom_range(0, 7)),
                  plfs_pkg::DATA_W'($urandom()));
      end
      cfg_valid <= 1'b0;

      // One phase runs against a long receiver hold so the block backs up.
      if (phase == 2) begin
        hold_results = 1;
      end

      // Most positions hover around the target just outside and inside the
      // deadband; the rest are full-range or pinned at the ends.
      mid  = int'(steer_sb.regs.target);
      span = int'(steer_sb.regs.dead_zone) + 60;
      for (int n = 0; n < PHASE_WORDS; n++) begin
        case ($urandom_range(0, 9))
          0:       pos = $urandom_range(0, 1) ? 1023 : 0;
          1, 2, 3: pos = $urandom_range(0, 1023);
          default: pos = mid - span + int'($urandom_range(0, 2 * span));
        endcase
        if (pos < 0) begin
          pos = 0;
        end else if (pos > 1023) begin
          pos = 1023;
        end
        send_position(plfs_pkg::POS_W'(pos));
      end
      wait_idle();
    end

    in_valid <= 1'b0;
    while (steer_sb.expected_steer.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (steer_sb.failures == 0) begin
      $display("pi_line_follow_steering_top verification clean");
    end else begin
      $display("pi_line_follow_steering_top verification failed");
    end
    $finish;
  end

endmodule
